[hw/rtl/rbm_pkg.sv]
package rbm_pkg;

    localparam int MAX_ATOMS  = 256;
    localparam int MAX_DEGREE = 8;
    localparam int MAX_BONDS  = 512;

    localparam int ATOM_W = $clog2(MAX_ATOMS);
    localparam int SLOT_W = $clog2(MAX_DEGREE);
    localparam int ADJ_AW = ATOM_W + SLOT_W;
    localparam int BOND_W = $clog2(MAX_BONDS);
    localparam int DEG_W  = 4;
    localparam int CNT_W  = 9;
    localparam int SUM_W  = 12;
    localparam int LBL_W  = 2;
    localparam int SP_W   = ATOM_W + 1;
    localparam int AC_W   = 9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);

    localparam logic [LBL_W-1:0] LBL_UNVISITED = 2'd0;
    localparam logic [LBL_W-1:0] LBL_VISITED   = 2'd1;
    localparam logic [LBL_W-1:0] LBL_CYCLE     = 2'd2;

    typedef enum logic [2:0] {
        FN_WR_ADJ  = 3'd0,
        FN_WR_DEG  = 3'd1,
        FN_RUN     = 3'd2,
        FN_RD_BOND = 3'd3,
        FN_RD_ATOM = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_RESP, ST_CLR, ST_ROOTRD, ST_ROOT,
        ST_DEG, ST_SLOT, ST_ADJ, ST_NB, ST_POP1, ST_POP2
    } t_state;

    typedef struct packed {
        logic [LBL_W-1:0] label;
        logic [CNT_W-1:0] cnt;
    } t_node;

    typedef struct packed {
        logic [ATOM_W-1:0] atom;
        logic [ATOM_W-1:0] parent;
        logic              has_parent;
        logic [DEG_W-1:0]  deg;
        logic [DEG_W-1:0]  next_slot;
        logic [SUM_W-1:0]  sum;
        logic [BOND_W-1:0] child_bond;
    } t_frame;

    typedef struct packed {
        logic [ATOM_W-1:0] nb;
        logic [BOND_W-1:0] bond;
    } t_adj;

endpackage

[hw/rtl/ring_bond_marker.sv]
// Loads, degree writes and mark queries: result strobe registered from the response
// state, no new start taken before idle again. The receiver cannot stall o_done.
// Run: clears the node memory, then walks slots and pops atoms; the walk is bounded
// by the state memories, each with one read port and one write port.
// Reset (sync, active low) starts a clearing pass over the bond, degree and node
// memories; busy stays high until it finishes.
module ring_bond_marker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_func,
    input  logic [7:0]                i_atom_id,
    input  logic [2:0]                i_slot,
    input  logic [7:0]                i_neighbor_atom,
    input  logic [8:0]                i_bond_id,
    input  logic [3:0]                i_degree,
    input  logic                      i_cfg_we,
    input  logic [8:0]                i_cfg_data,
    output logic                      o_done,
    output logic                      o_ring_mark,
    output logic [8:0]                o_open_cycles
);
    import rbm_pkg::*;

    // control and walk registers
    t_state            r_state, n_state;
    t_frame            r_top, n_top;        // top stack frame, lower frames in memory
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [BOND_W-1:0] r_cnt, n_cnt;        // sweep counter (init and run clear)
    logic [ATOM_W-1:0] r_nb, n_nb;
    logic [BOND_W-1:0] r_bd, n_bd;
    logic [SUM_W-1:0]  r_ret, n_ret;        // cycles handed back to the parent
    t_func             r_func, n_func;
    logic [AC_W-1:0]   r_atom_count;
    logic              r_done, n_done;
    logic              r_mark, n_mark;
    logic [CNT_W-1:0]  r_cycles, n_cycles;

    // memory ports
    logic              adj_we;
    t_adj              adj_wdata, adj_rdata;
    logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
    logic              deg_we;
    logic [ATOM_W-1:0] deg_waddr, deg_raddr;
    logic [DEG_W-1:0]  deg_wdata, deg_rdata;
    logic              node_we;
    logic [ATOM_W-1:0] node_waddr, node_raddr;
    t_node             node_wdata, node_rdata;
    logic              bond_we;
    logic [BOND_W-1:0] bond_waddr, bond_raddr;
    logic              bond_wdata, bond_rdata;
    logic              stk_we;
    logic [ATOM_W-1:0] stk_waddr, stk_raddr;
    t_frame            stk_wdata, stk_rdata;

    logic              accept;
    logic [AC_W-1:0]   clr_n;
    logic [SP_W-1:0]   sp_m1, sp_m2;
    logic              slot_left;
    logic              back_to_parent;
    logic [SUM_W-1:0]  pop_r;

    assign accept    = start && (r_state == ST_IDLE);
    assign clr_n     = (r_atom_count > AC_W'(MAX_ATOMS)) ? AC_W'(MAX_ATOMS) : r_atom_count;
    assign sp_m1     = r_sp - 1'b1;
    assign sp_m2     = r_sp - SP_W'(2);
    assign slot_left = r_top.next_slot < r_top.deg;
    assign back_to_parent = r_top.has_parent && (adj_rdata.nb == r_top.parent);
    // a returning frame with open cycles closes one if a cycle started here
    assign pop_r = (r_top.sum != '0 && node_rdata.cnt != '0) ? r_top.sum - 1'b1
                                                             : r_top.sum;

    rbm_ram #(.WIDTH($bits(t_adj)), .DEPTH(MAX_ATOMS * MAX_DEGREE)) u_adj_ram (
        .i_clk, .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    rbm_ram #(.WIDTH(DEG_W), .DEPTH(MAX_ATOMS)) u_deg_ram (
        .i_clk, .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_rdata)
    );
    rbm_ram #(.WIDTH($bits(t_node)), .DEPTH(MAX_ATOMS)) u_node_ram (
        .i_clk, .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );
    rbm_ram #(.WIDTH(1), .DEPTH(MAX_BONDS)) u_bond_ram (
        .i_clk, .i_we(bond_we), .i_waddr(bond_waddr), .i_wdata(bond_wdata),
        .i_raddr(bond_raddr), .o_rdata(bond_rdata)
    );
    rbm_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_ATOMS)) u_stk_ram (
        .i_clk, .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_cnt == BOND_W'(MAX_BONDS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (t_func'(i_func) == FN_RUN) begin
                        n_state = (clr_n == '0) ? ST_ROOTRD : ST_CLR;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RESP: n_state = ST_IDLE;
            ST_CLR: begin
                if (AC_W'(r_cnt) == clr_n - 1'b1) n_state = ST_ROOTRD;
            end
            ST_ROOTRD: n_state = ST_ROOT;
            ST_ROOT: begin
                n_state = (node_rdata.label == LBL_UNVISITED) ? ST_DEG : ST_IDLE;
            end
            ST_DEG: n_state = ST_SLOT;
            ST_SLOT: n_state = slot_left ? ST_ADJ : ST_POP1;
            ST_ADJ: n_state = back_to_parent ? ST_SLOT : ST_NB;
            ST_NB: begin
                if (node_rdata.label == LBL_UNVISITED && r_sp != SP_W'(MAX_ATOMS)) begin
                    n_state = ST_DEG;
                end else begin
                    n_state = ST_SLOT;
                end
            end
            ST_POP1: n_state = (sp_m1 == '0) ? ST_IDLE : ST_POP2;
            ST_POP2: n_state = ST_SLOT;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_top    = r_top;
        n_sp     = r_sp;
        n_cnt    = r_cnt;
        n_nb     = r_nb;
        n_bd     = r_bd;
        n_ret    = r_ret;
        n_func   = r_func;
        n_done   = 1'b0;
        n_mark   = 1'b0;
        n_cycles = '0;

        adj_we     = 1'b0;
        adj_waddr  = {i_atom_id, i_slot};
        adj_wdata  = '{nb: i_neighbor_atom, bond: i_bond_id};
        adj_raddr  = {r_top.atom, r_top.next_slot[SLOT_W-1:0]};
        deg_we     = 1'b0;
        deg_waddr  = i_atom_id;
        deg_wdata  = i_degree;
        deg_raddr  = r_nb;
        node_we    = 1'b0;
        node_waddr = r_nb;
        node_wdata = node_rdata;
        node_raddr = i_atom_id;
        bond_we    = 1'b0;
        bond_waddr = r_bd;
        bond_wdata = 1'b1;
        bond_raddr = i_bond_id;
        stk_we     = 1'b0;
        stk_waddr  = sp_m1[ATOM_W-1:0];
        stk_wdata  = r_top;
        stk_raddr  = sp_m2[ATOM_W-1:0];

        unique case (r_state)
            ST_INIT: begin
                // clear bond flags, degrees and node state after reset
                bond_we    = 1'b1;
                bond_waddr = r_cnt;
                bond_wdata = 1'b0;
                deg_we     = 1'b1;
                deg_waddr  = r_cnt[ATOM_W-1:0];
                deg_wdata  = '0;
                node_we    = 1'b1;
                node_waddr = r_cnt[ATOM_W-1:0];
                node_wdata = '0;
                n_cnt      = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_func = t_func'(i_func);
                    unique case (t_func'(i_func))
                        FN_WR_ADJ: adj_we = 1'b1;
                        FN_WR_DEG: deg_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_RESP: begin
                n_done = 1'b1;
                unique case (r_func)
                    FN_RD_BOND: n_mark = bond_rdata;
                    FN_RD_ATOM: n_mark = (node_rdata.label == LBL_CYCLE);
                    default:    n_mark = 1'b0;
                endcase
            end
            ST_CLR: begin
                node_we    = 1'b1;
                node_waddr = r_cnt[ATOM_W-1:0];
                node_wdata = '0;
                n_cnt      = r_cnt + 1'b1;
            end
            ST_ROOTRD: begin
                node_raddr = '0;
            end
            ST_ROOT: begin
                node_waddr = '0;
                n_sp       = '0;
                if (node_rdata.label == LBL_UNVISITED) begin
                    node_we          = 1'b1;
                    node_wdata.label = LBL_VISITED;
                    n_top            = '0;
                    n_sp             = SP_W'(1);
                    deg_raddr        = '0;
                end else if (node_rdata.label == LBL_VISITED) begin
                    node_we = 1'b1;
                    if (node_rdata.cnt != CNT_MAX) node_wdata.cnt = node_rdata.cnt + 1'b1;
                    n_done   = 1'b1;
                    n_cycles = CNT_W'(1);
                end else begin
                    n_done = 1'b1;
                end
            end
            ST_DEG: begin
                n_top.deg = (deg_rdata > DEG_MAX) ? DEG_MAX : deg_rdata;
            end
            ST_SLOT: begin
                if (slot_left) begin
                    n_top.next_slot = r_top.next_slot + 1'b1;
                end else begin
                    node_raddr = r_top.atom;
                end
            end
            ST_ADJ: begin
                n_nb       = adj_rdata.nb;
                n_bd       = adj_rdata.bond;
                node_raddr = adj_rdata.nb;
            end
            ST_NB: begin
                if (node_rdata.label == LBL_UNVISITED) begin
                    n_top.child_bond = r_bd;
                    if (r_sp != SP_W'(MAX_ATOMS)) begin
                        // push: current top goes to memory, child becomes top
                        stk_we                = 1'b1;
                        stk_wdata.child_bond  = r_bd;
                        node_we               = 1'b1;
                        node_wdata.label      = LBL_VISITED;
                        n_top                 = '0;
                        n_top.atom            = r_nb;
                        n_top.parent          = r_top.atom;
                        n_top.has_parent      = 1'b1;
                        n_sp                  = r_sp + 1'b1;
                    end
                end else if (node_rdata.label == LBL_VISITED) begin
                    // back edge: a cycle opens at the neighbor
                    node_we = 1'b1;
                    if (node_rdata.cnt != CNT_MAX) node_wdata.cnt = node_rdata.cnt + 1'b1;
                    bond_we   = 1'b1;
                    n_top.sum = r_top.sum + 1'b1;
                end
            end
            ST_POP1: begin
                node_waddr = r_top.atom;
                if (r_top.sum != '0) begin
                    node_we = 1'b1;
                    if (node_rdata.cnt != '0) begin
                        node_wdata.cnt = node_rdata.cnt - 1'b1;
                    end else begin
                        node_wdata.label = LBL_CYCLE;
                    end
                end
                n_sp  = sp_m1;
                n_ret = pop_r;
                if (sp_m1 == '0) begin
                    n_done   = 1'b1;
                    n_cycles = (pop_r > SUM_W'(CNT_MAX)) ? CNT_MAX : pop_r[CNT_W-1:0];
                end
            end
            ST_POP2: begin
                n_top      = stk_rdata;
                n_top.sum  = stk_rdata.sum + r_ret;
                bond_waddr = stk_rdata.child_bond;
                bond_we    = (r_ret != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_sp         <= '0;
            r_cnt        <= '0;
            r_atom_count <= AC_W'(1);
            r_done       <= 1'b0;
            r_mark       <= 1'b0;
            r_cycles     <= '0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
            r_mark   <= n_mark;
            r_cycles <= n_cycles;
            if (i_cfg_we) r_atom_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_nb   <= n_nb;
        r_bd   <= n_bd;
        r_ret  <= n_ret;
        r_func <= n_func;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_ring_mark   = r_mark;
    assign o_open_cycles = r_cycles;
endmodule

[hw/rtl/rbm_ram.sv]
module rbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/rbm_checker.sv]
module rbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_ring_mark,
    input logic [8:0] o_open_cycles
);
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_ring_mark && o_open_cycles == 9'd0)
        else $error("result ports active without strobe");
endmodule

bind ring_bond_marker rbm_checker u_rbm_checker (.*);
